// File: rtl/shortest_path_count_mod_core_assert.svh
`ifndef SHORTEST_PATH_COUNT_MOD_CORE_ASSERT_SVH
`define SHORTEST_PATH_COUNT_MOD_CORE_ASSERT_SVH

// check cons in the same cycle as ante
`define SPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spc assertion failed");

// check cons in the cycle after ante
`define SPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spc assertion failed");

`endif

// File: rtl/spc_pkg.sv
package spc_pkg;

	localparam int COUNT_W    = 30;
	localparam int NODE_W     = 8;
	localparam int OUT_DIST_W = 48;

	localparam logic [COUNT_W-1:0] PRIME = 30'd1000000007;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_INIT   = 10'b0000000010,
		ST_SCAN   = 10'b0000000100,
		ST_SETTLE = 10'b0000001000,
		ST_EREAD  = 10'b0000010000,
		ST_ECHK   = 10'b0000100000,
		ST_NREAD  = 10'b0001000000,
		ST_NUPD   = 10'b0010000000,
		ST_ORD    = 10'b0100000000,
		ST_OWR    = 10'b1000000000
	} state_t;

endpackage

// File: rtl/spc_edge_mem.sv
module spc_edge_mem #(
	parameter int EAW         = 10,
	parameter int WEIGHT_BITS = 32
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [EAW-1:0]                waddr,
	input  logic [spc_pkg::NODE_W-1:0]    wr_a,
	input  logic [spc_pkg::NODE_W-1:0]    wr_b,
	input  logic [WEIGHT_BITS-1:0]        wr_w,
	input  logic [EAW-1:0]                raddr,
	output logic [spc_pkg::NODE_W-1:0]    rd_a,
	output logic [spc_pkg::NODE_W-1:0]    rd_b,
	output logic [WEIGHT_BITS-1:0]        rd_w
);

	localparam int DEPTH = 1 << EAW;

	logic [spc_pkg::NODE_W-1:0] mem_a [DEPTH];
	logic [spc_pkg::NODE_W-1:0] mem_b [DEPTH];
	logic [WEIGHT_BITS-1:0]     mem_w [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_a[waddr] <= wr_a;
			mem_b[waddr] <= wr_b;
			mem_w[waddr] <= wr_w;
		end
		rd_a <= mem_a[raddr];
		rd_b <= mem_b[raddr];
		rd_w <= mem_w[raddr];
	end

endmodule

// File: rtl/spc_node_mem.sv
module spc_node_mem #(
	parameter int NAW       = 8,
	parameter int DIST_BITS = 48
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [NAW-1:0]                        waddr,
	input  logic [spc_pkg::COUNT_W+DIST_BITS:0]   wdata,
	input  logic [NAW-1:0]                        raddr,
	output logic [spc_pkg::COUNT_W+DIST_BITS:0]   rdata
);

	localparam int DEPTH = 1 << NAW;

	logic [spc_pkg::COUNT_W+DIST_BITS:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/shortest_path_count_mod_core.sv
// Edge word: stored at the next edge slot while the store has room, else dropped.
// Run word: initialize the state of all MAX_NODES node slots, then per settled
// node scan the active nodes and pass over every stored edge, then read the result
// of the last node; the node memory port sets the pace. Not ready during a run
// or while a result waits. Reset empties the edge store and sets node_count 1.
`include "shortest_path_count_mod_core_assert.svh"

module shortest_path_count_mod_core #(
	parameter int MAX_NODES   = 256,
	parameter int MAX_EDGES   = 1024,
	parameter int WEIGHT_BITS = 32,
	parameter int DIST_BITS   = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // from_node, to_node, edge_weight
	input  logic        s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // path_count, shortest_distance, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data
);

	localparam int NAW = $clog2(MAX_NODES);
	localparam int NCW = $clog2(MAX_NODES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int CW  = spc_pkg::COUNT_W;
	localparam int NWW = 1 + CW + DIST_BITS;
	localparam logic [DIST_BITS-1:0] DIST_ONES = '1;

	spc_pkg::state_t state_q;

	logic [8:0]             node_count_q;
	logic [NCW-1:0]         nodes_q;
	logic [ECW-1:0]         stored_q;
	logic [ECW-1:0]         e_q;
	logic [NCW-1:0]         init_i_q;
	logic [NCW-1:0]         scan_i_q;
	logic                   rd_v_s1;
	logic [NAW-1:0]         rd_idx_s1;
	logic [DIST_BITS-1:0]   least_q;
	logic [NAW-1:0]         pick_q;
	logic [CW-1:0]          pick_ways_q;
	logic                   found_q;
	logic [DIST_BITS-1:0]   cand_q;
	logic                   ovf_q;
	logic [NAW-1:0]         tgt_q;
	logic [NAW-1:0]         alt_q;
	logic                   pend_q;
	logic                   m_tvalid_q;
	logic [CW-1:0]          out_count_q;
	logic [spc_pkg::OUT_DIST_W-1:0] out_dist_q;

	logic                   edge_we;
	logic [spc_pkg::NODE_W-1:0] ed_a, ed_b;
	logic [WEIGHT_BITS-1:0] ed_w;

	logic                   nd_we;
	logic [NAW-1:0]         nd_waddr, nd_raddr;
	logic [NWW-1:0]         nd_wdata, nd_rdata;
	logic                   nd_settled;
	logic [CW-1:0]          nd_ways;
	logic [DIST_BITS-1:0]   nd_dist;

	logic                   accept;
	logic [31:0]            nc32;
	logic [NCW-1:0]         nodes_next;
	logic                   scan_issue, scan_done;
	logic                   last_edge;
	logic                   a_ok, b_ok, hit_a, hit_b;
	logic [64:0]            w_x, room_x;
	logic [CW:0]            way_sum;
	logic [CW-1:0]          way_mod;
	logic                   upd_less, upd_eq;
	logic [63:0]            dist64;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == spc_pkg::ST_IDLE) && !m_tvalid_q;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {2'b00, out_dist_q, out_count_q};

	assign nc32 = 32'(node_count_q);
	always_comb begin
		if (nc32 == 32'd0) begin
			nodes_next = NCW'(1);
		end else if (nc32 > 32'(MAX_NODES)) begin
			nodes_next = NCW'(MAX_NODES);
		end else begin
			nodes_next = NCW'(nc32);
		end
	end

	assign edge_we = accept && !s_tuser && (stored_q < ECW'(MAX_EDGES));

	spc_edge_mem #(
		.EAW         (EAW),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_edge_mem (
		.clk   (clk),
		.we    (edge_we),
		.waddr (stored_q[EAW-1:0]),
		.wr_a  (s_tdata[7:0]),
		.wr_b  (s_tdata[15:8]),
		.wr_w  (s_tdata[16 +: WEIGHT_BITS]),
		.raddr (e_q[EAW-1:0]),
		.rd_a  (ed_a),
		.rd_b  (ed_b),
		.rd_w  (ed_w)
	);

	spc_node_mem #(
		.NAW       (NAW),
		.DIST_BITS (DIST_BITS)
	) u_node_mem (
		.clk   (clk),
		.we    (nd_we),
		.waddr (nd_waddr),
		.wdata (nd_wdata),
		.raddr (nd_raddr),
		.rdata (nd_rdata)
	);

	assign nd_settled = nd_rdata[NWW-1];
	assign nd_ways    = nd_rdata[DIST_BITS +: CW];
	assign nd_dist    = nd_rdata[DIST_BITS-1:0];

	assign scan_issue = scan_i_q < nodes_q;
	assign scan_done  = !scan_issue && !rd_v_s1;
	assign last_edge  = (e_q + ECW'(1)) == stored_q;

	assign a_ok   = 32'(ed_a) < 32'(nodes_q);
	assign b_ok   = 32'(ed_b) < 32'(nodes_q);
	assign hit_a  = a_ok && b_ok && (32'(ed_a) == 32'(pick_q));
	assign hit_b  = a_ok && b_ok && (32'(ed_b) == 32'(pick_q));
	assign w_x    = 65'(ed_w);
	assign room_x = 65'(DIST_ONES - least_q);

	assign way_sum  = {1'b0, nd_ways} + {1'b0, pick_ways_q};
	assign way_mod  = (way_sum >= {1'b0, spc_pkg::PRIME}) ?
		CW'(way_sum - {1'b0, spc_pkg::PRIME}) : way_sum[CW-1:0];
	assign upd_less = !nd_settled && !ovf_q && (cand_q < nd_dist);
	assign upd_eq   = !nd_settled && !ovf_q && (cand_q == nd_dist);

	always_comb begin
		nd_we    = 1'b0;
		nd_waddr = pick_q;
		nd_wdata = {1'b1, pick_ways_q, least_q};
		nd_raddr = scan_i_q[NAW-1:0];
		unique case (state_q)
			spc_pkg::ST_INIT: begin
				nd_we    = 1'b1;
				nd_waddr = init_i_q[NAW-1:0];
				nd_wdata = (init_i_q == '0) ? {1'b0, CW'(1), {DIST_BITS{1'b0}}}
					: {1'b0, {CW{1'b0}}, DIST_ONES};
			end
			spc_pkg::ST_SETTLE: begin
				nd_we = 1'b1;
			end
			spc_pkg::ST_NREAD: begin
				nd_raddr = tgt_q;
			end
			spc_pkg::ST_NUPD: begin
				nd_we    = upd_less || upd_eq;
				nd_waddr = tgt_q;
				nd_wdata = upd_less ? {1'b0, pick_ways_q, cand_q}
					: {1'b0, way_mod, nd_dist};
			end
			spc_pkg::ST_ORD: begin
				nd_raddr = NAW'(nodes_q - NCW'(1));
			end
			default: begin
			end
		endcase
	end

	assign dist64 = 64'(nd_dist);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= spc_pkg::ST_IDLE;
			node_count_q <= 9'd1;
			nodes_q      <= NCW'(1);
			stored_q     <= '0;
			e_q          <= '0;
			init_i_q     <= '0;
			scan_i_q     <= '0;
			rd_v_s1      <= 1'b0;
			rd_idx_s1    <= '0;
			least_q      <= DIST_ONES;
			pick_q       <= '0;
			pick_ways_q  <= '0;
			found_q      <= 1'b0;
			cand_q       <= '0;
			ovf_q        <= 1'b0;
			tgt_q        <= '0;
			alt_q        <= '0;
			pend_q       <= 1'b0;
			m_tvalid_q   <= 1'b0;
			out_count_q  <= '0;
			out_dist_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (edge_we) begin
				stored_q <= stored_q + ECW'(1);
			end
			unique case (state_q)
				spc_pkg::ST_IDLE: begin
					if (accept && s_tuser) begin
						nodes_q  <= nodes_next;
						init_i_q <= '0;
						state_q  <= spc_pkg::ST_INIT;
					end
				end
				spc_pkg::ST_INIT: begin
					init_i_q <= init_i_q + NCW'(1);
					if (init_i_q == NCW'(MAX_NODES - 1)) begin
						scan_i_q <= '0;
						rd_v_s1  <= 1'b0;
						least_q  <= DIST_ONES;
						found_q  <= 1'b0;
						state_q  <= spc_pkg::ST_SCAN;
					end
				end
				spc_pkg::ST_SCAN: begin
					if (scan_issue) begin
						scan_i_q <= scan_i_q + NCW'(1);
					end
					rd_v_s1   <= scan_issue;
					rd_idx_s1 <= scan_i_q[NAW-1:0];
					if (rd_v_s1 && !nd_settled && (nd_dist < least_q)) begin
						least_q     <= nd_dist;
						pick_q      <= rd_idx_s1;
						pick_ways_q <= nd_ways;
						found_q     <= 1'b1;
					end
					if (scan_done) begin
						state_q <= found_q ? spc_pkg::ST_SETTLE : spc_pkg::ST_ORD;
					end
				end
				spc_pkg::ST_SETTLE: begin
					e_q <= '0;
					if (stored_q == '0) begin
						scan_i_q <= '0;
						rd_v_s1  <= 1'b0;
						least_q  <= DIST_ONES;
						found_q  <= 1'b0;
						state_q  <= spc_pkg::ST_SCAN;
					end else begin
						state_q <= spc_pkg::ST_EREAD;
					end
				end
				spc_pkg::ST_EREAD: begin
					state_q <= spc_pkg::ST_ECHK;
				end
				spc_pkg::ST_ECHK: begin
					ovf_q  <= w_x >= room_x;
					cand_q <= least_q + w_x[DIST_BITS-1:0];
					alt_q  <= NAW'(ed_a);
					if (hit_a) begin
						tgt_q   <= NAW'(ed_b);
						pend_q  <= hit_b;
						state_q <= spc_pkg::ST_NREAD;
					end else if (hit_b) begin
						tgt_q   <= NAW'(ed_a);
						pend_q  <= 1'b0;
						state_q <= spc_pkg::ST_NREAD;
					end else if (last_edge) begin
						scan_i_q <= '0;
						rd_v_s1  <= 1'b0;
						least_q  <= DIST_ONES;
						found_q  <= 1'b0;
						state_q  <= spc_pkg::ST_SCAN;
					end else begin
						e_q     <= e_q + ECW'(1);
						state_q <= spc_pkg::ST_EREAD;
					end
				end
				spc_pkg::ST_NREAD: begin
					state_q <= spc_pkg::ST_NUPD;
				end
				spc_pkg::ST_NUPD: begin
					if (pend_q) begin
						tgt_q   <= alt_q;
						pend_q  <= 1'b0;
						state_q <= spc_pkg::ST_NREAD;
					end else if (last_edge) begin
						scan_i_q <= '0;
						rd_v_s1  <= 1'b0;
						least_q  <= DIST_ONES;
						found_q  <= 1'b0;
						state_q  <= spc_pkg::ST_SCAN;
					end else begin
						e_q     <= e_q + ECW'(1);
						state_q <= spc_pkg::ST_EREAD;
					end
				end
				spc_pkg::ST_ORD: begin
					state_q <= spc_pkg::ST_OWR;
				end
				spc_pkg::ST_OWR: begin
					out_count_q <= nd_ways;
					out_dist_q  <= dist64[spc_pkg::OUT_DIST_W-1:0];
					m_tvalid_q  <= 1'b1;
					state_q     <= spc_pkg::ST_IDLE;
				end
				default: begin
					state_q <= spc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	`SPC_ASSERT_NEXT(a_run_starts_init, clk, arst_n, accept && s_tuser, state_q == spc_pkg::ST_INIT)
	`SPC_ASSERT_NOW(a_count_below_prime, clk, arst_n, m_tvalid_q, out_count_q < spc_pkg::PRIME)
	`SPC_ASSERT_NOW(a_pick_in_range, clk, arst_n, state_q == spc_pkg::ST_SETTLE, found_q && (NCW'(pick_q) < nodes_q))

endmodule

// File: bench/tb_shortest_path_count_mod_core.sv
`timescale 1ns / 1ps

module tb_shortest_path_count_mod_core;

	localparam int NODE_SLOTS = 256;
	localparam int EDGE_SLOTS = 1024;
	localparam logic [spc_pkg::OUT_DIST_W-1:0] NO_ROUTE = '1;
	localparam longint CYCLE_LIMIT = 40000000;

	typedef enum bit {REQ_EDGE = 1'b0, REQ_RUN = 1'b1} req_t;
	typedef enum logic [1:0] {ROW_CFG, ROW_EDGE, ROW_RUN} row_kind_t;

	typedef struct {
		logic [spc_pkg::COUNT_W-1:0]    ways;
		logic [spc_pkg::OUT_DIST_W-1:0] span;
	} route_t;

	typedef struct {
		row_kind_t                      kind;
		logic [8:0]                     nodes;
		logic [spc_pkg::NODE_W-1:0]     a;
		logic [spc_pkg::NODE_W-1:0]     b;
		logic [31:0]                    w;
		bit                             typed;
		logic [spc_pkg::COUNT_W-1:0]    ways;
		logic [spc_pkg::OUT_DIST_W-1:0] span;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [8:0]  cfg_data = '0;

	logic [spc_pkg::NODE_W-1:0] lane_a [EDGE_SLOTS];
	logic [spc_pkg::NODE_W-1:0] lane_b [EDGE_SLOTS];
	logic [31:0]                lane_w [EDGE_SLOTS];
	int                         lanes_held = 0;
	logic [8:0]                 node_reg = 9'd1;

	route_t routes_due [$];
	row_t   rows [$];
	int     errors = 0;
	int     routes_seen = 0;
	int     burst_left = 0;
	int     hold_cycles = 0;
	bit     hold_armed = 0;
	bit     long_hold_done = 0;
	bit     stall_mode = 0;
	longint cycles = 0;

	shortest_path_count_mod_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void queue_route(input route_t r);
		routes_due = {routes_due, r};
	endfunction

	function automatic void add_row(input row_t r);
		rows = {rows, r};
	endfunction

	function automatic route_t count_routes();
		logic [63:0]                 best [NODE_SLOTS];
		logic [spc_pkg::COUNT_W-1:0] ways [NODE_SLOTS];
		bit                          done [NODE_SLOTS];
		logic [63:0]                 all_ones, least, cand, w;
		logic [spc_pkg::COUNT_W:0]   sum;
		int                          n, pick, ends, from_n, to_n;
		route_t                      r;
		all_ones = {16'd0, NO_ROUTE};
		n = (node_reg == 0) ? 1 : (node_reg > NODE_SLOTS) ? NODE_SLOTS : node_reg;
		for (int i = 0; i < NODE_SLOTS; i++) begin
			best[i] = all_ones;
			ways[i] = '0;
			done[i] = 0;
		end
		best[0] = 0;
		ways[0] = 1;
		forever begin
			pick = n;
			least = all_ones;
			for (int i = 0; i < n; i++)
				if (!done[i] && best[i] < least) begin
					least = best[i];
					pick = i;
				end
			if (pick >= n) break;
			done[pick] = 1;
			for (int e = 0; e < lanes_held; e++) begin
				if (lane_a[e] >= n || lane_b[e] >= n) continue;
				w = {32'd0, lane_w[e]};
				for (int s = 0; s < 2; s++) begin
					from_n = s ? lane_b[e] : lane_a[e];
					to_n = s ? lane_a[e] : lane_b[e];
					if (from_n != pick || done[to_n]) continue;
					if (w >= all_ones - best[pick]) continue;
					cand = best[pick] + w;
					if (cand < best[to_n]) begin
						best[to_n] = cand;
						ways[to_n] = ways[pick];
					end else if (cand == best[to_n]) begin
						sum = ways[to_n] + ways[pick];
						if (sum >= spc_pkg::PRIME) sum -= spc_pkg::PRIME;
						ways[to_n] = sum[spc_pkg::COUNT_W-1:0];
					end
				end
			end
		end
		ends = n - 1;
		r.ways = ways[ends];
		r.span = best[ends][spc_pkg::OUT_DIST_W-1:0];
		return r;
	endfunction

	task automatic write_nodes(input logic [8:0] v);
		s_tvalid <= 1'b0;
		wait (routes_due.size() == 0);
		@(negedge clk);
		repeat (20) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		node_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_word(input req_t req, input logic [7:0] a, input logic [7:0] b,
			input logic [31:0] w, input bit typed, input route_t fixed);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {w, b, a};
		do @(posedge clk); while (!s_tready);
		if (req == REQ_EDGE) begin
			if (lanes_held < EDGE_SLOTS) begin
				lane_a[lanes_held] = a;
				lane_b[lanes_held] = b;
				lane_w[lanes_held] = w;
				lanes_held++;
			end
		end else
			queue_route(typed ? fixed : count_routes());
		@(negedge clk);
	endtask

	task automatic send_edge(input logic [7:0] a, input logic [7:0] b, input logic [31:0] w);
		route_t none;
		none = '{default: '0};
		send_word(REQ_EDGE, a, b, w, 0, none);
	endtask

	task automatic send_run();
		route_t none;
		none = '{default: '0};
		send_word(REQ_RUN, 8'($urandom), 8'($urandom), $urandom, 0, none);
	endtask

	always @(posedge clk) begin
		route_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			routes_seen++;
			if (routes_due.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				exp_r = routes_due.pop_front();
				if (m_tdata[29:0] !== exp_r.ways) begin
					$error("path_count expected %0d actual %0d", exp_r.ways, m_tdata[29:0]);
					errors++;
				end
				if (m_tdata[77:30] !== exp_r.span) begin
					$error("shortest_distance expected %h actual %h", exp_r.span,
						m_tdata[77:30]);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_armed && m_tvalid && !long_hold_done) begin
			long_hold_done = 1;
			hold_cycles = 3000;
		end
		if ($urandom_range(0, 99) == 0) stall_mode = ~stall_mode;
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_tready <= 1'b0;
		end else
			m_tready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		route_t fixed;
		int     sent, nodes, burst;
		logic [7:0] a, b;
		logic [31:0] w;

		add_row('{ROW_RUN, 0, 0, 0, 0, 1, 1, 0});
		add_row('{ROW_CFG, 2, 0, 0, 0, 0, 0, 0});
		add_row('{ROW_RUN, 0, 0, 0, 0, 1, 0, NO_ROUTE});
		add_row('{ROW_EDGE, 0, 0, 1, 32'hFFFF_FFFF, 0, 0, 0});
		add_row('{ROW_EDGE, 0, 1, 0, 1, 0, 0, 0});
		add_row('{ROW_EDGE, 0, 0, 1, 1, 0, 0, 0});
		add_row('{ROW_RUN, 0, 0, 0, 0, 0, 0, 0});
		add_row('{ROW_EDGE, 0, 1, 1, 5, 0, 0, 0});
		add_row('{ROW_EDGE, 0, 0, 255, 1, 0, 0, 0});
		add_row('{ROW_RUN, 0, 0, 0, 0, 0, 0, 0});
		add_row('{ROW_CFG, 0, 0, 0, 0, 0, 0, 0});
		add_row('{ROW_RUN, 0, 0, 0, 0, 1, 1, 0});
		add_row('{ROW_CFG, 256, 0, 0, 0, 0, 0, 0});
		add_row('{ROW_RUN, 0, 0, 0, 0, 0, 0, 0});
		add_row('{ROW_EDGE, 0, 255, 1, 32'hAAAA_5555, 0, 0, 0});
		add_row('{ROW_RUN, 0, 0, 0, 0, 0, 0, 0});
		add_row('{ROW_CFG, 511, 0, 0, 0, 0, 0, 0});
		add_row('{ROW_RUN, 0, 0, 0, 0, 0, 0, 0});
		add_row('{ROW_CFG, 3, 0, 0, 0, 0, 0, 0});
		add_row('{ROW_EDGE, 0, 0, 2, 0, 0, 0, 0});
		add_row('{ROW_EDGE, 0, 2, 1, 1, 0, 0, 0});
		add_row('{ROW_EDGE, 0, 2, 1, 1, 0, 0, 0});
		add_row('{ROW_RUN, 0, 0, 0, 0, 0, 0, 0});

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			fixed.ways = rows[i].ways;
			fixed.span = rows[i].span;
			case (rows[i].kind)
				ROW_CFG: write_nodes(rows[i].nodes);
				ROW_EDGE: send_edge(rows[i].a, rows[i].b, rows[i].w);
				default: send_word(REQ_RUN, 8'hFF, 8'hFF, '1, rows[i].typed, fixed);
			endcase
		end

		// three parallel unit edges per hop: the count wraps past the prime
		write_nodes(20);
		for (int i = 0; i < 19; i++)
			repeat (3) send_edge(8'(i), 8'(i + 1), 1);
		send_run();

		sent = 0;
		while (sent < 520) begin
			nodes = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
			write_nodes(9'(nodes));
			burst = $urandom_range(2, 14);
			repeat (burst) begin
				a = ($urandom_range(0, 9) == 0) ? 8'($urandom)
					: 8'($urandom_range(0, nodes - 1));
				b = ($urandom_range(0, 9) == 0) ? 8'($urandom)
					: 8'($urandom_range(0, nodes - 1));
				w = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 6);
				send_edge(a, b, w);
				sent++;
			end
			send_run();
			sent++;
			if ($urandom_range(0, 2) == 0) begin
				send_edge(8'($urandom_range(0, nodes - 1)), 8'($urandom_range(0, nodes - 1)),
					$urandom_range(1, 6));
				send_run();
				sent += 2;
			end
		end

		write_nodes(4);
		hold_armed = 1;
		send_run();
		send_edge(0, 3, 1);
		send_edge(0, 3, 1);
		send_run();

		s_tvalid <= 1'b0;
		wait (routes_due.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: shortest_path_count_mod_core.f
+incdir+rtl
rtl/spc_pkg.sv
rtl/spc_edge_mem.sv
rtl/spc_node_mem.sv
rtl/shortest_path_count_mod_core.sv
bench/tb_shortest_path_count_mod_core.sv
